// ===== hdl/khr_pkg.sv =====
// shared constants, types and counter update function for the key hold/release tracker
`timescale 1ns / 1ps
package khr_pkg;

    localparam int NUM_KEYS   = 256;
    localparam int ADDR_W     = $clog2(NUM_KEYS);
    localparam int KEY_W      = 8;
    localparam int CNT_W      = 16;
    localparam int DUR_W      = 15;
    localparam int NUM_WATCH  = 4;
    localparam int SLOT_W     = 2;
    localparam int LATEST_W   = 3;
    localparam int CFG_IDX_W  = 8;

    typedef logic signed [CNT_W-1:0] t_cnt;
    typedef logic [KEY_W-1:0]        t_key;
    typedef logic [LATEST_W-1:0]     t_latest;

    localparam t_cnt CNT_MAX = t_cnt'((64'd1 << (CNT_W - 1)) - 64'd1);
    localparam t_cnt CNT_MIN = -CNT_MAX;
    localparam t_cnt CNT_ONE = t_cnt'(1);

    localparam t_latest LATEST_NONE = t_latest'(0);

    // restart on a level change, then step toward the held or released limit
    function automatic t_cnt f_next_count(input t_cnt old_cnt, input logic pressed);
        t_cnt c;
        c = old_cnt;
        if (pressed) begin
            if (c < 0) c = '0;
            if (c < CNT_MAX) c = c + CNT_ONE;
        end else begin
            if (c > 0) c = '0;
            if (c > CNT_MIN) c = c - CNT_ONE;
        end
        return c;
    endfunction

endpackage

// ===== hdl/khr_ram.sv =====
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module khr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/khr_latest.sv =====
// picks the watched slot with the shortest positive hold time
`timescale 1ns / 1ps
module khr_latest
    import khr_pkg::*;
(
    input  t_cnt    i_counts [NUM_WATCH],
    output t_latest o_latest
);

    logic    pick_a;
    logic    pick_c;
    logic    pick_lo;
    t_cnt    best_lo;
    t_cnt    best_hi;
    t_latest slot_lo;
    t_latest slot_hi;

    // lower slot wins unless it is not held or the higher one is strictly shorter
    always_comb begin
        pick_a  = (i_counts[0] > 0) && ((i_counts[1] <= 0) || (i_counts[0] <= i_counts[1]));
        best_lo = pick_a ? i_counts[0] : i_counts[1];
        slot_lo = pick_a ? t_latest'(1) : t_latest'(2);

        pick_c  = (i_counts[2] > 0) && ((i_counts[3] <= 0) || (i_counts[2] <= i_counts[3]));
        best_hi = pick_c ? i_counts[2] : i_counts[3];
        slot_hi = pick_c ? t_latest'(3) : t_latest'(4);

        pick_lo = (best_lo > 0) && ((best_hi <= 0) || (best_lo <= best_hi));
        if (pick_lo) begin
            o_latest = slot_lo;
        end else if (best_hi > 0) begin
            o_latest = slot_hi;
        end else begin
            o_latest = LATEST_NONE;
        end
    end

endmodule

// ===== hdl/key_hold_release_tracker.sv =====
// top level: per-key held/released frame counter with memory read-modify-write
`timescale 1ns / 1ps
// Takes one key sample per cycle unless an output stall or a watch-key write holds input
// off, and returns one registered result item per sample. Each key's signed count lives in
// one memory with a single read and a single write port; the read is issued as the item is
// accepted, the saturating update and write-back happen in the following stage once it can
// advance, and the last write is forwarded when it went to the same key, so back-to-back
// samples of one key are handled at full rate. Per-entry valid flags cleared by reset make
// every count start at zero with no clearing pass. A watch-key register write reloads the
// slot's count from memory in the following cycle; input is held off during that reload.
module key_hold_release_tracker
    import khr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [KEY_W-1:0]     i_key_index,
    input  logic                 i_key_pressed,
    input  logic                 i_frame_end,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [KEY_W-1:0]     o_key_id,
    output logic signed [CNT_W-1:0] o_key_count,
    output logic [DUR_W-1:0]     o_held_frames,
    output logic [DUR_W-1:0]     o_released_frames,
    output logic                 o_press_edge,
    output logic                 o_release_edge,
    output logic                 o_any_press_edge,
    output logic [LATEST_W-1:0]  o_latest_watched,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [KEY_W-1:0]     i_cfg_data
);

    // control
    logic              r_s1_valid;
    logic              r_out_valid;
    logic              r_cfg_pend;
    logic [SLOT_W-1:0] r_cfg_slot;
    logic              r_seen;
    logic              r_wr_vld;
    logic              r_vbit [NUM_KEYS];
    t_key              r_watch_key [NUM_WATCH];
    t_cnt              r_watched   [NUM_WATCH];

    // stage one payload
    logic [ADDR_W-1:0] r_rd_addr;
    logic              r_rd_vbit;
    logic              r_s1_pressed;
    logic              r_s1_fend;
    logic [ADDR_W-1:0] r_wr_addr;
    t_cnt              r_wr_data;

    logic              in_acc;
    logic              cfg_acc;
    logic              cfg_in_range;
    logic              s1_adv;
    logic              s1_fire;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    t_cnt              ram_rdata;
    t_cnt              old_cnt;
    t_cnt              n_cnt;
    t_cnt              n_neg;
    t_cnt              n_watched [NUM_WATCH];
    logic              n_pe;
    logic              n_re;
    t_latest           n_latest;

    assign s1_adv       = !r_out_valid || !i_out_stall;
    assign s1_fire      = r_s1_valid && s1_adv;
    assign o_in_stall   = (r_s1_valid && !s1_adv) || i_cfg_valid || r_cfg_pend;
    assign in_acc       = i_in_valid && !o_in_stall;
    assign o_cfg_ready  = !r_cfg_pend && !r_s1_valid;
    assign cfg_acc      = i_cfg_valid && o_cfg_ready;
    assign cfg_in_range = (i_cfg_index < CFG_IDX_W'(NUM_WATCH));

    assign ram_re    = in_acc || cfg_acc;
    assign ram_raddr = cfg_acc ? i_cfg_data[ADDR_W-1:0] : i_key_index[ADDR_W-1:0];

    khr_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_KEYS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_rd_addr),
        .i_wdata (n_cnt),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // forward the last write, which may have landed on the same edge as this read
    always_comb begin
        if (r_wr_vld && (r_wr_addr == r_rd_addr)) begin
            old_cnt = r_wr_data;
        end else if (r_rd_vbit) begin
            old_cnt = ram_rdata;
        end else begin
            old_cnt = '0;
        end
        n_cnt = f_next_count(old_cnt, r_s1_pressed);
        n_neg = -n_cnt;
        n_pe  = (n_cnt == CNT_ONE);
        n_re  = (n_cnt == -CNT_ONE);
        for (int i = 0; i < NUM_WATCH; i++) begin
            n_watched[i] = (r_watch_key[i][ADDR_W-1:0] == r_rd_addr) ? n_cnt : r_watched[i];
        end
    end

    khr_latest u_latest (
        .i_counts (n_watched),
        .o_latest (n_latest)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cfg_pend  <= 1'b0;
            r_cfg_slot  <= '0;
            r_seen      <= 1'b0;
            r_wr_vld    <= 1'b0;
            for (int i = 0; i < NUM_KEYS; i++) begin
                r_vbit[i] <= 1'b0;
            end
            for (int i = 0; i < NUM_WATCH; i++) begin
                r_watch_key[i] <= '0;
                r_watched[i]   <= '0;
            end
        end else begin
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_adv || !r_s1_valid) begin
                r_s1_valid <= in_acc;
            end
            if (cfg_acc) begin
                r_cfg_pend <= cfg_in_range;
                r_cfg_slot <= i_cfg_index[SLOT_W-1:0];
                if (cfg_in_range) begin
                    r_watch_key[i_cfg_index[SLOT_W-1:0]] <= i_cfg_data;
                end
            end else begin
                r_cfg_pend <= 1'b0;
            end
            if (r_cfg_pend) begin
                r_watched[r_cfg_slot] <= old_cnt;
            end
            if (s1_fire) begin
                r_vbit[r_rd_addr] <= 1'b1;
                r_wr_vld          <= 1'b1;
                for (int i = 0; i < NUM_WATCH; i++) begin
                    r_watched[i] <= n_watched[i];
                end
                r_seen <= r_s1_fend ? 1'b0 : (r_seen || n_pe);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_rd_addr    <= ram_raddr;
            r_rd_vbit    <= r_vbit[ram_raddr];
            r_s1_pressed <= i_key_pressed;
            r_s1_fend    <= i_frame_end;
        end
        if (s1_fire) begin
            r_wr_addr         <= r_rd_addr;
            r_wr_data         <= n_cnt;
            o_key_id          <= KEY_W'(r_rd_addr);
            o_key_count       <= n_cnt;
            o_held_frames     <= (n_cnt > 0) ? n_cnt[DUR_W-1:0] : '0;
            o_released_frames <= (n_cnt < 0) ? n_neg[DUR_W-1:0] : '0;
            o_press_edge      <= n_pe;
            o_release_edge    <= n_re;
            o_any_press_edge  <= r_s1_fend && (r_seen || n_pe);
            o_latest_watched  <= r_s1_fend ? n_latest : LATEST_NONE;
        end
    end

    assign o_out_valid = r_out_valid;

    a_edges_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_press_edge && o_release_edge))
        else $error("press and release edge on one item");

    a_press_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_press_edge) |-> (o_key_count == CNT_ONE && o_held_frames == DUR_W'(1)))
        else $error("press edge without a count of one");

    a_durations_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_held_frames != '0) |-> (o_released_frames == '0))
        else $error("held and released durations both nonzero");

    a_latest_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_latest_watched <= LATEST_W'(NUM_WATCH)))
        else $error("latest watched slot out of range");

    a_cfg_reload_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cfg_pend |-> (!r_s1_valid && !$past(in_acc)))
        else $error("slot reload overlaps an item in flight");

endmodule
